@@ rtl/lhti_pkg.sv @@
`timescale 1ns / 1ps
package lhti_pkg;
   localparam int MAX_BUCKETS      = 64;
   localparam int SLOTS_PER_BUCKET = 8;
   localparam int OVERFLOW_SLOTS   = 8;
   localparam int BUCKET_STRIDE    = SLOTS_PER_BUCKET + OVERFLOW_SLOTS;
   localparam int BW  = $clog2(MAX_BUCKETS);
   localparam int SW  = $clog2(BUCKET_STRIDE);
   localparam int FW  = $clog2(BUCKET_STRIDE + 1);
   localparam int KAW = BW + SW;
   localparam int CW  = $clog2(MAX_BUCKETS + 1);
   localparam int DVW = CW + 1;
   localparam int RCW = $clog2(MAX_BUCKETS * BUCKET_STRIDE + 1);
   localparam int KEY_W = 32;

   localparam logic CSR_CAPACITY = 1'b0;
   localparam logic CSR_INITIAL  = 1'b1;

   localparam logic [1:0] ST_PRIMARY  = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_REJECTED = 2'd2;

   typedef struct packed {
      logic             start;
      logic [KEY_W-1:0] dividend;
      logic [DVW-1:0]   divisor;
   } rem_req_type;

   typedef struct packed {
      logic           done;
      logic [DVW-1:0] rem;
   } rem_rsp_type;
endpackage

@@ rtl/lhti_ram.sv @@
`timescale 1ns / 1ps
module lhti_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/lhti_rem.sv @@
`timescale 1ns / 1ps
module lhti_rem (
   input  logic                 clock,
   input  logic                 reset,
   input  lhti_pkg::rem_req_type req,
   output lhti_pkg::rem_rsp_type rsp
);
   import lhti_pkg::*;

   logic [KEY_W-1:0] q_ff, q_in;
   logic [DVW-1:0]   r_ff, r_in, d_ff, d_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DVW:0]     trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {r_ff, q_ff[KEY_W-1]};
      if (req.start) begin
         q_in    = req.dividend;
         r_in    = '0;
         d_in    = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = {q_ff[KEY_W-2:0], 1'b0};
         r_in   = (trial >= {1'b0, d_ff}) ? DVW'(trial - {1'b0, d_ff}) : trial[DVW-1:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = r_ff;

   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("remainder done while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req.start |=> busy_ff) else $error("remainder not busy after start");
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (r_ff < d_ff)) else $error("remainder not below divisor");
endmodule

@@ rtl/linear_hash_table_insert.sv @@
`timescale 1ns / 1ps
// An insert without split runs from the accepting edge to rsp_tvalid through the
//   bit-serial remainder unit, bucket choice, fill update and output register.
// A split adds a rehash of each key held in the split bucket (up to 16), one after another.
// The block takes one word at a time: req_tready is high only in the idle state.
// Reset and a write of initial_buckets empty the table at once (fill valid bits cleared).
module linear_hash_table_insert (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] key
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [7:2] home_bucket, [8] split_done, [15:9] bucket_total,
   // [21:16] split_position, [32:22] records_held, [39:33] zero
   output logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [5:0]  csr_data
);
   import lhti_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DIV  = 4'd1;
   localparam logic [3:0] S_FUSE = 4'd2;
   localparam logic [3:0] S_SRD  = 4'd3;
   localparam logic [3:0] S_SGET = 4'd4;
   localparam logic [3:0] S_KRD  = 4'd5;
   localparam logic [3:0] S_KGET = 4'd6;
   localparam logic [3:0] S_KDIV = 4'd7;
   localparam logic [3:0] S_KWR  = 4'd8;
   localparam logic [3:0] S_FWV  = 4'd9;
   localparam logic [3:0] S_FWN  = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;

   logic [3:0]       state_ff, state_in;
   logic [3:0]       cap_ff, cap_in, cap_eff;
   logic [CW-1:0]    bc_ff, bc_in, lm_ff, lm_in;
   logic [BW-1:0]    sp_ff, sp_in;
   logic [RCW-1:0]   rc_ff, rc_in;
   logic [MAX_BUCKETS-1:0] valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [BW-1:0]    home_ff, home_in, victim_ff, victim_in, newb_ff, newb_in;
   logic [DVW-1:0]   wide_ff, wide_in;
   logic [1:0]       status_ff, status_in;
   logic             split_ff, split_in;
   logic [FW-1:0]    n_ff, n_in, slot_ff, slot_in, cv_ff, cv_in, cn_ff, cn_in;
   logic             rv_ff, rv_in;
   logic [39:0]      rd_ff, rd_in;

   rem_req_type      rreq;
   rem_rsp_type      rrsp;

   logic             k_we, f_we;
   logic [KAW-1:0]   k_waddr, k_raddr;
   logic [KEY_W-1:0] k_wdata, k_rdata;
   logic [BW-1:0]    f_waddr, f_raddr;
   logic [FW-1:0]    f_wdata, f_rdata, fill;
   logic [CW-1:0]    r_low, init_eff;
   logic [CW:0]      sp_next;
   logic [BW-1:0]    home_calc;

   lhti_ram #(.WIDTH(KEY_W), .DEPTH(MAX_BUCKETS * BUCKET_STRIDE)) u_keys (
      .clock(clock), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
      .raddr(k_raddr), .rdata(k_rdata));

   lhti_ram #(.WIDTH(FW), .DEPTH(MAX_BUCKETS)) u_fill (
      .clock(clock), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
      .raddr(f_raddr), .rdata(f_rdata));

   lhti_rem u_rem (.clock(clock), .reset(reset), .req(rreq), .rsp(rrsp));

   assign cap_eff  = (cap_ff == 4'd0) ? 4'd1 :
                     (cap_ff > 4'(SLOTS_PER_BUCKET)) ? 4'(SLOTS_PER_BUCKET) : cap_ff;
   assign init_eff = (csr_data == 6'd0) ? CW'(1) :
                     ({1'b0, csr_data} > 7'(MAX_BUCKETS)) ? CW'(MAX_BUCKETS) : CW'(csr_data);
   assign r_low    = (rrsp.rem >= {1'b0, lm_ff}) ? CW'(rrsp.rem - {1'b0, lm_ff})
                                                 : rrsp.rem[CW-1:0];
   assign home_calc = (r_low < CW'(sp_ff)) ? rrsp.rem[BW-1:0] : r_low[BW-1:0];
   assign fill     = valid_ff[f_raddr] ? f_rdata : '0;
   assign sp_next  = {2'b00, sp_ff} + (CW+1)'(1);
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      cap_in    = cap_ff;
      bc_in     = bc_ff;
      lm_in     = lm_ff;
      sp_in     = sp_ff;
      rc_in     = rc_ff;
      valid_in  = valid_ff;
      key_in    = key_ff;
      home_in   = home_ff;
      victim_in = victim_ff;
      newb_in   = newb_ff;
      wide_in   = wide_ff;
      status_in = status_ff;
      split_in  = split_ff;
      n_in      = n_ff;
      slot_in   = slot_ff;
      cv_in     = cv_ff;
      cn_in     = cn_ff;
      rv_in     = rv_ff;
      rd_in     = rd_ff;
      rreq      = '0;
      k_we      = 1'b0;
      k_waddr   = {home_ff, fill[SW-1:0]};
      k_wdata   = key_ff;
      k_raddr   = {victim_ff, slot_ff[SW-1:0]};
      f_we      = 1'b0;
      f_waddr   = home_ff;
      f_wdata   = fill + FW'(1);
      f_raddr   = home_ff;

      if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            rreq.dividend = req_tdata;
            rreq.divisor  = {lm_ff, 1'b0};
            if (req_tvalid) begin
               rreq.start = 1'b1;
               key_in     = req_tdata;
               split_in   = 1'b0;
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            f_raddr = home_calc;
            if (rrsp.done) begin
               home_in  = home_calc;
               state_in = S_FUSE;
            end
         end
         S_FUSE: begin
            if (fill < FW'(cap_eff)) begin
               status_in = ST_PRIMARY;
               k_we  = 1'b1;
               f_we  = 1'b1;
               valid_in[home_ff] = 1'b1;
               rc_in = rc_ff + RCW'(1);
               state_in = S_OUT;
            end else if (fill < FW'(cap_eff) + FW'(OVERFLOW_SLOTS)) begin
               status_in = ST_OVERFLOW;
               k_we  = 1'b1;
               f_we  = 1'b1;
               valid_in[home_ff] = 1'b1;
               rc_in = rc_ff + RCW'(1);
               if (bc_ff < CW'(MAX_BUCKETS)) begin
                  split_in  = 1'b1;
                  victim_in = sp_ff;
                  newb_in   = bc_ff[BW-1:0];
                  wide_in   = {lm_ff, 1'b0};
                  bc_in     = bc_ff + CW'(1);
                  if (sp_next >= {1'b0, lm_ff}) begin
                     sp_in = '0;
                     lm_in = CW'({lm_ff, 1'b0});
                  end else begin
                     sp_in = sp_next[BW-1:0];
                  end
                  state_in = S_SRD;
               end else begin
                  state_in = S_OUT;
               end
            end else begin
               status_in = ST_REJECTED;
               state_in  = S_OUT;
            end
         end
         S_SRD: begin
            f_raddr  = victim_ff;
            state_in = S_SGET;
         end
         S_SGET: begin
            f_raddr = victim_ff;
            n_in    = fill;
            slot_in = '0;
            cv_in   = '0;
            cn_in   = '0;
            state_in = (fill == '0) ? S_FWV : S_KRD;
         end
         S_KRD: begin
            state_in = S_KGET;
         end
         S_KGET: begin
            rreq.start    = 1'b1;
            rreq.dividend = k_rdata;
            rreq.divisor  = wide_ff;
            key_in        = k_rdata;
            state_in      = S_KDIV;
         end
         S_KDIV: begin
            if (rrsp.done) begin
               state_in = S_KWR;
            end
         end
         S_KWR: begin
            k_we = 1'b1;
            if (rrsp.rem == DVW'(victim_ff)) begin
               k_waddr = {victim_ff, cv_ff[SW-1:0]};
               cv_in   = cv_ff + FW'(1);
            end else begin
               k_waddr = {newb_ff, cn_ff[SW-1:0]};
               cn_in   = cn_ff + FW'(1);
            end
            slot_in  = slot_ff + FW'(1);
            state_in = (slot_ff + FW'(1) == n_ff) ? S_FWV : S_KRD;
         end
         S_FWV: begin
            f_we    = 1'b1;
            f_waddr = victim_ff;
            f_wdata = cv_ff;
            valid_in[victim_ff] = 1'b1;
            state_in = S_FWN;
         end
         S_FWN: begin
            f_we    = 1'b1;
            f_waddr = newb_ff;
            f_wdata = cn_ff;
            valid_in[newb_ff] = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1;
               rd_in = {7'd0, rc_ff, sp_ff, bc_ff, split_ff, home_ff, status_ff};
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            CSR_CAPACITY: cap_in = csr_data[3:0];
            CSR_INITIAL: begin
               valid_in = '0;
               bc_in    = init_eff;
               lm_in    = init_eff;
               sp_in    = '0;
               rc_in    = '0;
            end
            default: cap_in = cap_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cap_ff   <= 4'd4;
         bc_ff    <= CW'(2);
         lm_ff    <= CW'(2);
         sp_ff    <= '0;
         rc_ff    <= '0;
         valid_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cap_ff   <= cap_in;
         bc_ff    <= bc_in;
         lm_ff    <= lm_in;
         sp_ff    <= sp_in;
         rc_ff    <= rc_in;
         valid_ff <= valid_in;
         rv_ff    <= rv_in;
      end
      key_ff    <= key_in;
      home_ff   <= home_in;
      victim_ff <= victim_in;
      newb_ff   <= newb_in;
      wide_ff   <= wide_in;
      status_ff <= status_in;
      split_ff  <= split_in;
      n_ff      <= n_in;
      slot_ff   <= slot_in;
      cv_ff     <= cv_in;
      cn_ff     <= cn_in;
      rd_ff     <= rd_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

   a_sp_below: assert property (@(posedge clock) disable iff (reset)
      CW'(sp_ff) < lm_ff) else $error("split pointer beyond modulus");
   a_bc_sum: assert property (@(posedge clock) disable iff (reset)
      bc_ff == lm_ff + CW'(sp_ff)) else $error("bucket count out of step");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_DIV)) else $error("accept lost");
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_KWR) |-> (slot_ff < n_ff)) else $error("rehash past fill");
endmodule
